FILE: rtl/bpp_pkg.sv
package bpp_pkg;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 128;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PALETTE_N = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3    = 3'd5;

  // Reset values
  localparam logic [DIM_W-1:0]   DIM_RESET       = 8'd32;
  localparam logic [COLOR_W-1:0] PALETTE_0_RESET = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] PALETTE_1_RESET = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] PALETTE_2_RESET = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] PALETTE_3_RESET = 32'hFF48_6FB0;

  typedef logic [PALETTE_N-1:0][COLOR_W-1:0] palette_t;

  // One plane-1 byte, paired and classified, ready to be expanded into pixels
  typedef struct packed {
    logic [BYTE_W-1:0]    p0;
    logic [BYTE_W-1:0]    p1;
    logic [COL_W-1:0]     col;
    logic [COORD_W-1:0]   row;
    logic [BIT_IDX_W-1:0] last_idx;
    logic                 img_last;
  } job_t;

endpackage

FILE: rtl/bpp_front.sv
module bpp_front #(
  parameter int unsigned MaxWidth  = bpp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = bpp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bpp_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [bpp_pkg::DIM_W-1:0]  cfg_width_i,
  input  logic [bpp_pkg::DIM_W-1:0]  cfg_height_i,
  output logic                       push_o,
  output bpp_pkg::job_t              job_o,
  input  logic                       full_i
);
  import bpp_pkg::*;

  localparam int unsigned RowBytesMax = ((MaxWidth + 15) >> 4) * 2;
  localparam int unsigned ByteW       = $clog2(RowBytesMax);
  localparam int unsigned RowW        = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned AddrW       = RowW + ByteW;
  localparam int unsigned StoreDepth  = MaxHeight << ByteW;
  localparam int unsigned XW          = ByteW + 3;
  localparam int unsigned CmpW        = ((XW > DIM_W) ? XW : DIM_W) + 1;
  localparam int unsigned RowCmpW     = ((RowW > DIM_W) ? RowW : DIM_W) + 1;

  logic [ByteW-1:0] byte_q, byte_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             plane_q, plane_d;
  logic             st_v_q, st_v_d;
  job_t             st_job_q;
  logic [BYTE_W-1:0] st_p0_q;
  logic [BYTE_W-1:0] store_mem [StoreDepth];

  logic [DIM_W-1:0]  w, h;
  logic [CmpW-1:0]   wx, xb, rem;
  logic [DIM_W-2:0]  rb_half;
  logic [DIM_W-1:0]  rb;
  logic              has_pix, byte_end, row_end, row_last, accept;
  logic [AddrW-1:0]  addr;
  job_t              meta;

  assign in_stall_o = st_v_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = st_v_q && !full_i;
  assign addr       = {row_q, byte_q};

  always_comb begin
    // clamp geometry
    if (cfg_width_i == '0) begin
      w = DIM_W'(1);
    end else if (CmpW'(cfg_width_i) > CmpW'(MaxWidth)) begin
      w = DIM_W'(MaxWidth);
    end else begin
      w = cfg_width_i;
    end
    if (cfg_height_i == '0) begin
      h = DIM_W'(1);
    end else if (RowCmpW'(cfg_height_i) > RowCmpW'(MaxHeight)) begin
      h = DIM_W'(MaxHeight);
    end else begin
      h = cfg_height_i;
    end

    rb_half  = (DIM_W-1)'(({1'b0, w} + 9'd15) >> 4);
    rb       = {rb_half, 1'b0};
    wx       = CmpW'(w);
    xb       = CmpW'({byte_q, 3'b000});
    has_pix  = xb < wx;
    rem      = wx - xb;
    row_last = (RowCmpW'(row_q) + RowCmpW'(1)) == RowCmpW'(h);
    row_end  = (RowCmpW'(row_q) + RowCmpW'(1)) >= RowCmpW'(h);
    byte_end = (CmpW'(byte_q) + CmpW'(1)) >= CmpW'(rb);

    meta          = '0;
    meta.p1       = data_byte_i;
    meta.col      = COL_W'(byte_q);
    meta.row      = COORD_W'(row_q);
    meta.last_idx = (rem >= CmpW'(8)) ? 3'd7 : BIT_IDX_W'(rem - CmpW'(1));
    meta.img_last = has_pix && row_last && ((xb + CmpW'(8)) >= wx);

    byte_d  = byte_q;
    row_d   = row_q;
    plane_d = plane_q;
    st_v_d  = push_o ? 1'b0 : st_v_q;
    if (accept) begin
      st_v_d = plane_q && has_pix;
      if (byte_end) begin
        byte_d = '0;
        if (row_end) begin
          row_d   = '0;
          plane_d = !plane_q;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        byte_d = byte_q + ByteW'(1);
      end
    end
  end

  always_comb begin
    job_o    = st_job_q;
    job_o.p0 = st_p0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      row_q   <= '0;
      plane_q <= 1'b0;
      st_v_q  <= 1'b0;
    end else begin
      byte_q  <= byte_d;
      row_q   <= row_d;
      plane_q <= plane_d;
      st_v_q  <= st_v_d;
    end
  end

  // line store: plane 0 writes, plane 1 reads into the staging register
  always_ff @(posedge clk_i) begin
    if (accept && !plane_q) begin
      store_mem[addr] <= data_byte_i;
    end
    if (accept && plane_q) begin
      st_p0_q <= store_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_job_q <= meta;
    end
  end

endmodule

FILE: rtl/bpp_job_fifo.sv
module bpp_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bpp_pkg::job_t job_o
);
  import bpp_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/bpp_back.sv
module bpp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  bpp_pkg::job_t                 job_i,
  output logic                          pop_o,
  input  bpp_pkg::palette_t             palette_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpp_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic [bpp_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [bpp_pkg::COORD_W-1:0]   pixel_y_o,
  output logic                          last_of_byte_o,
  output logic                          last_of_image_o
);
  import bpp_pkg::*;

  logic                 busy_q, busy_d;
  job_t                 job_q;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 out_v_q, out_v_d;
  logic [COLOR_W-1:0]   color_q;
  logic [COORD_W-1:0]   x_q, y_q;
  logic                 lob_q, loi_q;

  logic                 adv, emit, last_bit;
  logic [BIT_IDX_W-1:0] sh;
  logic [1:0]           cidx;

  assign adv      = !out_v_q || !out_stall_i;
  assign emit     = adv && busy_q;
  assign last_bit = bit_q == job_q.last_idx;
  assign pop_o    = job_valid_i && (!busy_q || (emit && last_bit));
  assign sh       = ~bit_q;
  assign cidx     = {job_q.p1[sh], job_q.p0[sh]};

  always_comb begin
    busy_d  = busy_q;
    bit_d   = bit_q;
    out_v_d = adv ? busy_q : out_v_q;
    if (emit) begin
      if (last_bit) begin
        busy_d = 1'b0;
      end else begin
        bit_d = bit_q + BIT_IDX_W'(1);
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      bit_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      bit_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      bit_q   <= bit_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      color_q <= palette_i[cidx];
      x_q     <= {job_q.col, bit_q};
      y_q     <= job_q.row;
      lob_q   <= last_bit;
      loi_q   <= last_bit && job_q.img_last;
    end
  end

  assign out_valid_o     = out_v_q;
  assign pixel_color_o   = color_q;
  assign pixel_x_o       = x_q;
  assign pixel_y_o       = y_q;
  assign last_of_byte_o  = lob_q;
  assign last_of_image_o = loi_q;

endmodule

FILE: rtl/bitplane_to_palette_pixels_top.sv
// Two-bitplane planar to chunky converter.
// Input channel (in_valid_i / in_stall_o / data_byte_i): one planar byte per
// transfer, all of bitplane 0 first, then all of bitplane 1, each row padded
// to whole 16-bit words. Plane-0 bytes go into an internal line store and
// give no output; each plane-1 byte is paired with its stored plane-0 byte.
// Output channel (out_valid_o / out_stall_i): one pixel per transfer with its
// palette colour, column, row and end-of-byte / end-of-image marks. Padding
// bits give no pixel.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write geometry
// and palette only while the block is idle.
// Throughput: the front takes a byte whenever in_stall_o is low; the pixel
// serialiser in the back end yields one pixel per cycle while out_stall_i
// is low, up to eight per plane-1 byte. The first pixel of a plane-1
// transfer passes the front staging register, which takes the line store
// read at the transfer edge, the job queue, serialiser and output register.
// The two-entry job queue lets the front keep taking bytes while the back
// end is held by out_stall_i; when the queue is full and the front holds a
// job, in_stall_o rises. A stalled pixel holds on the outputs. Reset clears
// counters, queue and output valid and restores the default geometry and
// palette; the line store is not cleared and needs no clearing pass.
module bitplane_to_palette_pixels_top #(
  parameter int unsigned MaxWidth  = bpp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = bpp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpp_pkg::BYTE_W-1:0]    data_byte_i,
  // pixel output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpp_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic [bpp_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [bpp_pkg::COORD_W-1:0]   pixel_y_o,
  output logic                          last_of_byte_o,
  output logic                          last_of_image_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpp_pkg::COLOR_W-1:0]   cfg_data_i
);
  import bpp_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  palette_t         palette_q;

  logic push, full, pop, job_valid;
  job_t front_job, head_job;

  // Registers are always ready to take a write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= DIM_RESET;
      height_q     <= DIM_RESET;
      palette_q[0] <= PALETTE_0_RESET;
      palette_q[1] <= PALETTE_1_RESET;
      palette_q[2] <= PALETTE_2_RESET;
      palette_q[3] <= PALETTE_3_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q      <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q     <= cfg_data_i[DIM_W-1:0];
        REG_PALETTE_0:    palette_q[0] <= cfg_data_i;
        REG_PALETTE_1:    palette_q[1] <= cfg_data_i;
        REG_PALETTE_2:    palette_q[2] <= cfg_data_i;
        REG_PALETTE_3:    palette_q[3] <= cfg_data_i;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Front: track row/column/plane, store plane 0, pair plane 1
  bpp_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .push_o       (push),
    .job_o        (front_job),
    .full_i       (full)
  );

  // Short queue decoupling the front from the serialiser
  bpp_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  // Back: expand each job into pixels, one per cycle while out_stall_i is low
  bpp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .palette_i       (palette_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_color_o   (pixel_color_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .last_of_byte_o  (last_of_byte_o),
    .last_of_image_o (last_of_image_o)
  );

endmodule

FILE: rtl/bpp_checker.sv
module bpp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bpp_pkg::COLOR_W-1:0]   pixel_color_o,
  input logic [bpp_pkg::COORD_W-1:0]   pixel_x_o,
  input logic [bpp_pkg::COORD_W-1:0]   pixel_y_o,
  input logic                          last_of_byte_o,
  input logic                          last_of_image_o
);

  // A stalled pixel stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("pixel dropped while stalled");

  // A stalled pixel keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_color_o) && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(last_of_byte_o) && $stable(last_of_image_o))
    else $error("stalled pixel changed");

  // End of image always closes a byte
  a_image_closes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_image_o |-> last_of_byte_o)
    else $error("last_of_image without last_of_byte");

  // The rightmost pixel of a byte always ends it
  a_bit7_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pixel_x_o[2:0] == 3'd7) |-> last_of_byte_o)
    else $error("pixel at bit 0 of a byte not marked last");

endmodule

bind bitplane_to_palette_pixels_top bpp_checker u_bpp_checker (.*);
